// File: rtl/qbfe_pkg.sv
// Shared types, constants and fixed-point helpers for the quartic boundary fit block.
// Used by qbfe_div, qbfe_acc and quartic_boundary_fit_extrema; depends on nothing.
package qbfe_pkg;

    localparam int FRAC_BITS = 16;
    localparam int W         = 32;
    localparam int TW        = 31;
    localparam int DIV_NW    = W + FRAC_BITS;
    localparam int DIV_DW    = W + 2;
    localparam int ACC_LAT   = 5;
    localparam int PIPE_LAT  = 4 * DIV_NW + 10 + ACC_LAT;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_ZERO = 2'd1;
    localparam logic [1:0] ST_SAT  = 2'd2;

    localparam logic signed [63:0] Q_MAX = 64'sd2147483647;
    localparam logic signed [63:0] Q_MIN = -64'sd2147483648;
    localparam logic signed [63:0] Q_RND = (64'sd1 <<< FRAC_BITS) - 64'sd1;

    typedef logic signed [W-1:0] t_q;

    typedef struct packed {
        t_q              start_pos;
        t_q              start_vel;
        t_q              start_acc;
        t_q              end_vel;
        t_q              end_acc;
        logic [TW-1:0]   duration;
    } t_in;

    typedef struct packed {
        t_q              coef0;
        t_q              coef1;
        t_q              coef2;
        t_q              coef3;
        t_q              coef4;
        t_q              acc_max;
        t_q              acc_min;
        t_q              jerk_max;
        t_q              jerk_min;
        logic [1:0]      status;
    } t_out;

    typedef struct packed {
        logic sat;
        t_q   v;
    } t_satq;

    // Per-item context carried alongside the long division pipelines.
    typedef struct packed {
        t_q              p0;
        t_q              v0;
        t_q              c2;
        logic [TW-1:0]   dur;
        logic            tz;
        logic            sat;
        t_q              c3;
        t_q              c4;
        t_q              va;
        t_q              vb;
        t_q              vc;
    } t_ctx;

    function automatic t_satq f_sat32(input logic signed [63:0] x);
        t_satq r;
        if (x > Q_MAX) begin
            r.sat = 1'b1;
            r.v   = Q_MAX[W-1:0];
        end else if (x < Q_MIN) begin
            r.sat = 1'b1;
            r.v   = Q_MIN[W-1:0];
        end else begin
            r.sat = 1'b0;
            r.v   = x[W-1:0];
        end
        return r;
    endfunction

    // Drop the fraction bits of a full product, rounding toward zero, then clamp.
    function automatic t_satq f_mulfix(input logic signed [63:0] p);
        logic signed [63:0] t;
        if (p < 0) begin
            t = (p + Q_RND) >>> FRAC_BITS;
        end else begin
            t = p >>> FRAC_BITS;
        end
        return f_sat32(t);
    endfunction

    function automatic logic [W-1:0] f_abs(input t_q x);
        logic [W-1:0] u;
        u = x;
        return x[W-1] ? (~u + 1'b1) : u;
    endfunction

    function automatic logic [DIV_NW-1:0] f_num(input t_q x);
        return {f_abs(x), {FRAC_BITS{1'b0}}};
    endfunction

    function automatic t_satq f_quo(input logic [DIV_NW-1:0] q, input logic neg);
        logic [63:0]        e;
        logic signed [63:0] s;
        e = 64'(q);
        s = neg ? -$signed(e) : $signed(e);
        return f_sat32(s);
    endfunction

endpackage

// File: rtl/qbfe_div.sv
// Pipelined restoring divider, one quotient bit per register stage.
// Unsigned magnitudes in, sign carried alongside; depends on qbfe_pkg.
module qbfe_div import qbfe_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_vld,
    input  logic [DIV_NW-1:0] i_num,
    input  logic [DIV_DW-1:0] i_den,
    input  logic              i_neg,
    output logic              o_vld,
    output logic [DIV_NW-1:0] o_quo,
    output logic              o_neg
);

    logic [DIV_DW-1:0] r_rem [1:DIV_NW-1];
    logic [DIV_DW-1:0] r_den [1:DIV_NW-1];
    logic [DIV_NW-1:0] r_nq  [1:DIV_NW];
    logic              r_neg [1:DIV_NW];
    logic              r_vld [1:DIV_NW];

    for (genvar s = 0; s < DIV_NW; s++) begin : g_stg
        logic [DIV_DW-1:0] a_rem;
        logic [DIV_DW-1:0] a_den;
        logic [DIV_NW-1:0] a_nq;
        logic              a_neg;
        logic              a_vld;
        logic [DIV_DW:0]   n_try;
        logic [DIV_DW:0]   n_diff;
        logic              n_bit;

        if (s == 0) begin : g_in
            assign a_rem = '0;
            assign a_den = i_den;
            assign a_nq  = i_num;
            assign a_neg = i_neg;
            assign a_vld = i_vld;
        end else begin : g_rg
            assign a_rem = r_rem[s];
            assign a_den = r_den[s];
            assign a_nq  = r_nq[s];
            assign a_neg = r_neg[s];
            assign a_vld = r_vld[s];
        end

        always_comb begin
            n_try  = {a_rem, a_nq[DIV_NW-1]};
            n_diff = n_try - {1'b0, a_den};
            n_bit  = (n_try >= {1'b0, a_den});
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s+1] <= 1'b0;
            end else begin
                r_vld[s+1] <= a_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            r_nq[s+1]  <= {a_nq[DIV_NW-2:0], n_bit};
            r_neg[s+1] <= a_neg;
        end

        if (s < DIV_NW - 1) begin : g_keep
            always_ff @(posedge i_clk) begin
                r_rem[s+1] <= n_bit ? n_diff[DIV_DW-1:0] : n_try[DIV_DW-1:0];
                r_den[s+1] <= a_den;
            end
        end
    end

    assign o_vld = r_vld[DIV_NW];
    assign o_quo = r_nq[DIV_NW];
    assign o_neg = r_neg[DIV_NW];

endmodule

// File: rtl/qbfe_acc.sv
// Five-stage evaluator of the acceleration 2c2 + 6c3*t + 12c4*t^2 at one time point.
// Saturating Q-format arithmetic from qbfe_pkg.
module qbfe_acc import qbfe_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_vld,
    input  t_q            i_c2x2,
    input  t_q            i_k3,
    input  t_q            i_k4,
    input  logic [TW-1:0] i_t,
    output logic          o_vld,
    output t_q            o_acc,
    output logic          o_sat
);

    logic               r1_vld, r2_vld, r3_vld, r4_vld, r5_vld;
    logic signed [63:0] r1_p1, r1_p2, r3_p3;
    t_q                 r1_c, r2_c, r3_c, r4_c;
    logic [TW-1:0]      r1_t, r2_t;
    t_q                 r2_m1, r2_m2, r3_m1, r4_m1, r4_m3, r5_acc;
    logic               r2_sat, r3_sat, r4_sat, r5_sat;
    t_satq              n_m1, n_m2, n_m3, n_acc;

    always_comb begin
        n_m1  = f_mulfix(r1_p1);
        n_m2  = f_mulfix(r1_p2);
        n_m3  = f_mulfix(r3_p3);
        n_acc = f_sat32(64'(r4_c) + 64'(r4_m1) + 64'(r4_m3));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
            r5_vld <= 1'b0;
        end else begin
            r1_vld <= i_vld;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
            r4_vld <= r3_vld;
            r5_vld <= r4_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_p1  <= $signed(i_k3) * $signed({1'b0, i_t});
        r1_p2  <= $signed(i_k4) * $signed({1'b0, i_t});
        r1_c   <= i_c2x2;
        r1_t   <= i_t;
        r2_m1  <= n_m1.v;
        r2_m2  <= n_m2.v;
        r2_sat <= n_m1.sat | n_m2.sat;
        r2_c   <= r1_c;
        r2_t   <= r1_t;
        r3_p3  <= $signed(r2_m2) * $signed({1'b0, r2_t});
        r3_m1  <= r2_m1;
        r3_c   <= r2_c;
        r3_sat <= r2_sat;
        r4_m3  <= n_m3.v;
        r4_m1  <= r3_m1;
        r4_c   <= r3_c;
        r4_sat <= r3_sat | n_m3.sat;
        r5_acc <= n_acc.v;
        r5_sat <= r4_sat | n_acc.sat;
    end

    assign o_vld = r5_vld;
    assign o_acc = r5_acc;
    assign o_sat = r5_sat;

endmodule

// File: rtl/quartic_boundary_fit_extrema.sv
// Top level of the quartic boundary fit: coefficient solve, vertex search, extrema.
// Depends on qbfe_pkg, qbfe_div and qbfe_acc.
//
// Usage: drive a boundary problem on i_item and raise start for one cycle; the item
// is taken at that edge, since busy is always low. A new item may be given in every
// cycle. Each item yields exactly one result on o_res, shown for a single cycle with
// o_res_vld high; results leave in the order the items came in.
// Throughput is one item per cycle. The latency is set by four chained restoring
// dividers of DIV_NW one-bit stages each (b0/T, then /T, then /2T, then the vertex
// division), plus the front end, inter-rank registers and acceleration evaluators.
// The receiver cannot hold results off, so nothing stalls inside: every stage moves
// on at each edge with its own valid bit.
// Synchronous reset clears all valid bits, so no result appears until an item
// reaches the end; data registers are not reset.
module quartic_boundary_fit_extrema import qbfe_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_in  i_item,
    output logic o_res_vld,
    output t_out o_res
);

    logic               n_take;
    t_satq              n1_b1;
    t_ctx               n1_ctx;
    t_ctx               n2_ctx, n3_ctx, n4_ctx, n5_ctx, n6_ctx, n7_ctx, n8_ctx;

    logic               r1_vld, r2_vld, r3_vld, r4_vld, r5_vld, r6_vld, r7_vld, r8_vld, r9_vld;
    t_ctx               r1_ctx, r2_ctx, r3_ctx, r4_ctx, r5_ctx, r6_ctx, r7_ctx, r8_ctx, r9_ctx;
    logic signed [63:0] r1_prod;
    logic signed [W:0]  r1_dvv, r2_dvv;
    t_q                 r1_b1, r2_b1, r3_b1, r2_m, r3_b0, r4_d1, r4_f1;

    t_ctx               r_c1 [0:DIV_NW-1];
    t_ctx               r_c2 [0:DIV_NW-1];
    t_ctx               r_c3 [0:DIV_NW-1];
    t_ctx               r_c4 [0:DIV_NW-1];

    logic               d1_vld, d2_vld, d3_vld, d4_vld;
    logic [DIV_NW-1:0]  d1_qb0, d1_qb1, d1_qe, d2_qu, d2_qf, d3_qg, d4_qv;
    logic               d1_nb0, d1_nb1, d1_ne, d2_nu, d2_nf, d3_ng, d4_nv;
    logic [DIV_DW-1:0]  n_den1, n_den3, n_den4, n_den2, n_denv;
    logic               n_negv;

    t_satq              n4_d1, n4_f1, n4_e, n5_u, n5_f, n6_g, n6_c3, n7_c4;
    t_satq              n8_k3, n8_k4, n8_k5;
    logic               n9_vok;
    logic               r9_vok;
    logic [TW-1:0]      r9_tv;
    t_q                 n_c2x2;

    logic               at_vld, av_vld, at_sat, av_sat;
    t_q                 at_acc, av_acc;

    t_ctx               r_ec  [0:ACC_LAT-1];
    logic               r_evok [0:ACC_LAT-1];
    logic signed [63:0] rj1_p;
    t_q                 rj2_m, rj3_jt, rj4_jt, rj5_jt;
    logic               rj2_sat, rj3_sat, rj4_sat, rj5_sat;
    t_satq              nj2_m, nj3_jt;

    t_ctx               n_fc;
    t_q                 n_amax, n_amin, n_j0;
    logic               n_sat;
    t_out               n_out;
    logic               r_out_vld;
    t_out               r_out;

    assign busy   = 1'b0;
    assign n_take = start & ~busy;

    // Front end: b1 = ae - a0, a0*T product, then b0 = ve - v0 - mulq(a0, T).
    always_comb begin
        n1_b1      = f_sat32(64'(i_item.end_acc) - 64'(i_item.start_acc));
        n1_ctx     = '0;
        n1_ctx.p0  = i_item.start_pos;
        n1_ctx.v0  = i_item.start_vel;
        n1_ctx.c2  = i_item.start_acc / 32'sd2;
        n1_ctx.dur = i_item.duration;
        n1_ctx.tz  = (i_item.duration == '0);
        n1_ctx.sat = n1_b1.sat;
    end

    t_satq n2_m, n3_b0;
    always_comb begin
        n2_m       = f_mulfix(r1_prod);
        n3_b0      = f_sat32(64'(r2_dvv) - 64'(r2_m));
        n2_ctx     = r1_ctx;
        n2_ctx.sat = r1_ctx.sat | n2_m.sat;
        n3_ctx     = r2_ctx;
        n3_ctx.sat = r2_ctx.sat | n3_b0.sat;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
        end else begin
            r1_vld <= n_take;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_ctx      <= n1_ctx;
        r1_prod     <= $signed(i_item.start_acc) * $signed({1'b0, i_item.duration});
        r1_dvv      <= (W+1)'(i_item.end_vel) - (W+1)'(i_item.start_vel);
        r1_b1       <= n1_b1.v;
        r2_ctx      <= n2_ctx;
        r2_m        <= n2_m.v;
        r2_dvv      <= r1_dvv;
        r2_b1       <= r1_b1;
        r3_ctx      <= n3_ctx;
        r3_b0       <= n3_b0.v;
        r3_b1       <= r2_b1;
    end

    // First division rank: b0/T, b1/T and b1/3T side by side.
    assign n_den1 = DIV_DW'(r3_ctx.dur);
    assign n_den3 = DIV_DW'(r3_ctx.dur) + DIV_DW'({r3_ctx.dur, 1'b0});

    qbfe_div u_d1b0 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_vld(r3_vld),
        .i_num(f_num(r3_b0)), .i_den(n_den1), .i_neg(r3_b0[W-1]),
        .o_vld(d1_vld), .o_quo(d1_qb0), .o_neg(d1_nb0)
    );
    qbfe_div u_d1b1 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_vld(r3_vld),
        .i_num(f_num(r3_b1)), .i_den(n_den1), .i_neg(r3_b1[W-1]),
        .o_vld(), .o_quo(d1_qb1), .o_neg(d1_nb1)
    );
    qbfe_div u_d1e (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_vld(r3_vld),
        .i_num(f_num(r3_b1)), .i_den(n_den3), .i_neg(r3_b1[W-1]),
        .o_vld(), .o_quo(d1_qe), .o_neg(d1_ne)
    );

    always_ff @(posedge i_clk) begin
        r_c1[0] <= r3_ctx;
        r_c2[0] <= r4_ctx;
        r_c3[0] <= r5_ctx;
        r_c4[0] <= r8_ctx;
        for (int i = 1; i < DIV_NW; i++) begin
            r_c1[i] <= r_c1[i-1];
            r_c2[i] <= r_c2[i-1];
            r_c3[i] <= r_c3[i-1];
            r_c4[i] <= r_c4[i-1];
        end
    end

    always_comb begin
        n4_d1 = f_quo(d1_qb0, d1_nb0);
        n4_f1 = f_quo(d1_qb1, d1_nb1);
        n4_e  = f_quo(d1_qe, d1_ne);
        n5_u  = f_quo(d2_qu, d2_nu);
        n5_f  = f_quo(d2_qf, d2_nf);
        n6_g  = f_quo(d3_qg, d3_ng);
        n6_c3 = f_sat32(64'(r_c3[DIV_NW-1].va) - 64'(r_c3[DIV_NW-1].vc));
        n7_c4 = f_sat32(64'(r6_ctx.vb) - 64'(r6_ctx.va));
        n8_k3 = f_sat32(64'(r7_ctx.c3) * 64'sd6);
        n8_k4 = f_sat32(64'(r7_ctx.c4) * 64'sd12);
        n8_k5 = f_sat32(64'(r7_ctx.c4) * 64'sd24);

        n4_ctx     = r_c1[DIV_NW-1];
        n4_ctx.va  = n4_e.v;
        n4_ctx.sat = r_c1[DIV_NW-1].sat | n4_d1.sat | n4_f1.sat | n4_e.sat;

        // u, f and e travel together through the last coefficient division.
        n5_ctx     = r_c2[DIV_NW-1];
        n5_ctx.va  = n5_u.v;
        n5_ctx.vb  = n5_f.v;
        n5_ctx.vc  = r_c2[DIV_NW-1].va;
        n5_ctx.sat = r_c2[DIV_NW-1].sat | n5_u.sat | n5_f.sat;

        n6_ctx     = r_c3[DIV_NW-1];
        n6_ctx.va  = n6_g.v;
        n6_ctx.c3  = n6_c3.v;
        n6_ctx.sat = r_c3[DIV_NW-1].sat | n6_g.sat | n6_c3.sat;

        n7_ctx     = r6_ctx;
        n7_ctx.c4  = n7_c4.v;
        n7_ctx.sat = r6_ctx.sat | n7_c4.sat;

        n8_ctx     = r7_ctx;
        n8_ctx.va  = n8_k3.v;
        n8_ctx.vb  = n8_k4.v;
        n8_ctx.vc  = n8_k5.v;
        n8_ctx.sat = r7_ctx.sat | n8_k3.sat | n8_k4.sat | n8_k5.sat;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
            r5_vld <= 1'b0;
            r6_vld <= 1'b0;
            r7_vld <= 1'b0;
            r8_vld <= 1'b0;
            r9_vld <= 1'b0;
        end else begin
            r4_vld <= d1_vld;
            r5_vld <= d2_vld;
            r6_vld <= d3_vld;
            r7_vld <= r6_vld;
            r8_vld <= r7_vld;
            r9_vld <= d4_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r4_ctx     <= n4_ctx;
        r4_d1      <= n4_d1.v;
        r4_f1      <= n4_f1.v;
        r5_ctx     <= n5_ctx;
        r6_ctx     <= n6_ctx;
        r7_ctx     <= n7_ctx;
        r8_ctx     <= n8_ctx;
        r9_ctx     <= r_c4[DIV_NW-1];
        r9_vok     <= n9_vok;
        r9_tv      <= d4_qv[TW-1:0];
    end

    // Second rank: u = (b0/T)/T and f = (b1/T)/4T; third rank: g = u/2T.
    assign n_den4 = {1'b0, r4_ctx.dur, 2'b00};
    assign n_den2 = {2'b00, r5_ctx.dur, 1'b0};

    qbfe_div u_d2u (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_vld(r4_vld),
        .i_num(f_num(r4_d1)), .i_den(DIV_DW'(r4_ctx.dur)), .i_neg(r4_d1[W-1]),
        .o_vld(d2_vld), .o_quo(d2_qu), .o_neg(d2_nu)
    );
    qbfe_div u_d2f (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_vld(r4_vld),
        .i_num(f_num(r4_f1)), .i_den(n_den4), .i_neg(r4_f1[W-1]),
        .o_vld(), .o_quo(d2_qf), .o_neg(d2_nf)
    );
    qbfe_div u_d3g (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_vld(r5_vld),
        .i_num(f_num(r5_ctx.va)), .i_den(n_den2), .i_neg(r5_ctx.va[W-1]),
        .o_vld(d3_vld), .o_quo(d3_qg), .o_neg(d3_ng)
    );

    // Vertex time -c3 / (4 c4), kept exact; its sign is that of -c3 times c4.
    assign n_denv = {f_abs(r8_ctx.c4), 2'b00};
    assign n_negv = ((r8_ctx.c3 != '0) & ~r8_ctx.c3[W-1]) ^ r8_ctx.c4[W-1];

    qbfe_div u_d4v (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_vld(r8_vld),
        .i_num(f_num(r8_ctx.c3)), .i_den(n_denv), .i_neg(n_negv),
        .o_vld(d4_vld), .o_quo(d4_qv), .o_neg(d4_nv)
    );

    assign n9_vok = (r_c4[DIV_NW-1].c4 != '0) && (!d4_nv || d4_qv == '0)
                    && (d4_qv <= DIV_NW'(r_c4[DIV_NW-1].dur));

    assign n_c2x2 = $signed({r9_ctx.c2[W-2:0], 1'b0});

    qbfe_acc u_acc_t (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_vld(r9_vld),
        .i_c2x2(n_c2x2), .i_k3(r9_ctx.va), .i_k4(r9_ctx.vb), .i_t(r9_ctx.dur),
        .o_vld(at_vld), .o_acc(at_acc), .o_sat(at_sat)
    );
    qbfe_acc u_acc_v (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_vld(r9_vld),
        .i_c2x2(n_c2x2), .i_k3(r9_ctx.va), .i_k4(r9_ctx.vb), .i_t(r9_tv),
        .o_vld(av_vld), .o_acc(av_acc), .o_sat(av_sat)
    );

    // Jerk at T runs alongside the acceleration evaluators and lines up with them.
    always_comb begin
        nj2_m  = f_mulfix(rj1_p);
        nj3_jt = f_sat32(64'(r_ec[1].va) + 64'(rj2_m));
    end

    always_ff @(posedge i_clk) begin
        r_ec[0]   <= r9_ctx;
        r_evok[0] <= r9_vok;
        for (int i = 1; i < ACC_LAT; i++) begin
            r_ec[i]   <= r_ec[i-1];
            r_evok[i] <= r_evok[i-1];
        end
        rj1_p   <= $signed(r9_ctx.vc) * $signed({1'b0, r9_ctx.dur});
        rj2_m   <= nj2_m.v;
        rj2_sat <= nj2_m.sat;
        rj3_jt  <= nj3_jt.v;
        rj3_sat <= rj2_sat | nj3_jt.sat;
        rj4_jt  <= rj3_jt;
        rj4_sat <= rj3_sat;
        rj5_jt  <= rj4_jt;
        rj5_sat <= rj4_sat;
    end

    always_comb begin
        n_fc   = r_ec[ACC_LAT-1];
        n_amax = $signed({n_fc.c2[W-2:0], 1'b0});
        n_amin = n_amax;
        n_j0   = n_fc.va;
        if (at_acc > n_amax) begin
            n_amax = at_acc;
        end
        if (at_acc < n_amin) begin
            n_amin = at_acc;
        end
        if (r_evok[ACC_LAT-1]) begin
            if (av_acc > n_amax) begin
                n_amax = av_acc;
            end
            if (av_acc < n_amin) begin
                n_amin = av_acc;
            end
        end
        n_sat = n_fc.sat | at_sat | (r_evok[ACC_LAT-1] & av_sat) | rj5_sat;

        n_out       = '0;
        n_out.coef0 = n_fc.p0;
        n_out.coef1 = n_fc.v0;
        n_out.coef2 = n_fc.c2;
        if (n_fc.tz) begin
            // Zero duration: only the start terms are meaningful.
            n_out.acc_max = $signed({n_fc.c2[W-2:0], 1'b0});
            n_out.acc_min = $signed({n_fc.c2[W-2:0], 1'b0});
            n_out.status  = ST_ZERO;
        end else begin
            n_out.coef3    = n_fc.c3;
            n_out.coef4    = n_fc.c4;
            n_out.acc_max  = n_amax;
            n_out.acc_min  = n_amin;
            n_out.jerk_max = (n_j0 > rj5_jt) ? n_j0 : rj5_jt;
            n_out.jerk_min = (n_j0 < rj5_jt) ? n_j0 : rj5_jt;
            n_out.status   = n_sat ? ST_SAT : ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= at_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_res_vld = r_out_vld;
    assign o_res     = r_out;

    a_lat : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_vld |-> $past(start && !busy, PIPE_LAT))
        else $error("result without a matching accepted item");

    a_lanes : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        at_vld == av_vld)
        else $error("acceleration lanes out of step");

    a_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_vld && o_res.status == ST_ZERO) |->
        (o_res.coef3 == '0 && o_res.coef4 == '0 && o_res.jerk_max == '0
         && o_res.acc_max == o_res.acc_min))
        else $error("zero duration result not cleared");

    a_order : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_vld |-> (o_res.acc_max >= o_res.acc_min && o_res.jerk_max >= o_res.jerk_min))
        else $error("extrema out of order");

endmodule

// File: bench/qbfe_checker.sv
`timescale 1ns / 1ps
// Result checker for quartic_boundary_fit_extrema: predicts each result from the item.
// Depends on qbfe_pkg for the item and result types and the status codes.
module qbfe_checker import qbfe_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  start,
    input  logic  busy,
    input  t_in   i_item,
    input  logic  o_res_vld,
    input  t_out  o_res,
    output int    o_errors,
    output int    o_pending
);

    localparam longint QONE = longint'(1) << FRAC_BITS;
    localparam longint QHI  = 64'sd2147483647;
    localparam longint QLO  = -64'sd2147483648;

    t_out fit_queue[$];
    bit   clamped;

    function automatic longint clamp(longint x);
        if (x > QHI) begin
            clamped = 1'b1;
            return QHI;
        end
        if (x < QLO) begin
            clamped = 1'b1;
            return QLO;
        end
        return x;
    endfunction

    function automatic longint qmul(longint a, longint b);
        return clamp((a * b) / QONE);
    endfunction

    function automatic longint qdiv(longint a, longint b);
        return clamp((a * QONE) / b);
    endfunction

    function automatic longint accel(longint c2, longint k3, longint k4, longint t);
        return clamp(2 * c2 + qmul(k3, t) + qmul(qmul(k4, t), t));
    endfunction

    function automatic t_out solve_fit(t_in it);
        t_out   r;
        longint p0, v0, a0, ve, ae, dur, c2, c3, c4, amax, amin, jmax, jmin;
        longint b0, b1, u, k3, k4, k5, at, tv, jt;
        p0 = longint'(it.start_pos);
        v0 = longint'(it.start_vel);
        a0 = longint'(it.start_acc);
        ve = longint'(it.end_vel);
        ae = longint'(it.end_acc);
        dur = longint'({1'b0, it.duration});
        c2 = a0 / 2;
        c3 = 0;
        c4 = 0;
        jmax = 0;
        jmin = 0;
        clamped = 1'b0;
        amax = 2 * c2;
        amin = amax;
        if (dur == 0) begin
            r.status = ST_ZERO;
        end else begin
            b0 = clamp(ve - v0 - qmul(a0, dur));
            b1 = clamp(ae - a0);
            u  = qdiv(qdiv(b0, dur), dur);
            c3 = clamp(u - qdiv(b1, 3 * dur));
            c4 = clamp(qdiv(qdiv(b1, dur), 4 * dur) - qdiv(u, 2 * dur));
            k3 = clamp(6 * c3);
            k4 = clamp(12 * c4);
            k5 = clamp(24 * c4);
            at = accel(c2, k3, k4, dur);
            if (at > amax) amax = at;
            if (at < amin) amin = at;
            // The vertex only counts when it falls inside the interval.
            if (c4 != 0) begin
                tv = (-c3 * QONE) / (4 * c4);
                if (tv >= 0 && tv <= dur) begin
                    at = accel(c2, k3, k4, tv);
                    if (at > amax) amax = at;
                    if (at < amin) amin = at;
                end
            end
            jt = clamp(k3 + qmul(k5, dur));
            jmax = (k3 > jt) ? k3 : jt;
            jmin = (k3 < jt) ? k3 : jt;
            r.status = clamped ? ST_SAT : ST_OK;
        end
        r.coef0    = p0[31:0];
        r.coef1    = v0[31:0];
        r.coef2    = c2[31:0];
        r.coef3    = c3[31:0];
        r.coef4    = c4[31:0];
        r.acc_max  = amax[31:0];
        r.acc_min  = amin[31:0];
        r.jerk_max = jmax[31:0];
        r.jerk_min = jmin[31:0];
        return r;
    endfunction

    task automatic cmp_field(string fname, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, fname, want, got);
            o_errors++;
        end
    endtask

    initial begin
        o_errors  = 0;
        o_pending = 0;
    end

    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && start && !busy)
            fit_queue = {fit_queue, solve_fit(i_item)};
        if (i_rst_n && o_res_vld) begin
            if (fit_queue.size() == 0) begin
                $display("%0t: result with none expected, actual %h", $time, o_res);
                o_errors++;
            end else begin
                want = fit_queue.pop_front();
                cmp_field("coef0", want.coef0, o_res.coef0);
                cmp_field("coef1", want.coef1, o_res.coef1);
                cmp_field("coef2", want.coef2, o_res.coef2);
                cmp_field("coef3", want.coef3, o_res.coef3);
                cmp_field("coef4", want.coef4, o_res.coef4);
                cmp_field("acc_max", want.acc_max, o_res.acc_max);
                cmp_field("acc_min", want.acc_min, o_res.acc_min);
                cmp_field("jerk_max", want.jerk_max, o_res.jerk_max);
                cmp_field("jerk_min", want.jerk_min, o_res.jerk_min);
                cmp_field("status", 32'(want.status), 32'(o_res.status));
            end
        end
        o_pending = fit_queue.size();
    end

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps
// Stimulus and verdict for quartic_boundary_fit_extrema.
// Depends on qbfe_pkg, the block itself and qbfe_checker.
module tb import qbfe_pkg::*; ();

    localparam int STALL_LIMIT = 4 * PIPE_LAT + 2000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    t_in  i_item = '0;
    logic o_res_vld;
    t_out o_res;
    int   errors, pending, quiet;
    int   idle_pct;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    quartic_boundary_fit_extrema DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_item(i_item), .o_res_vld(o_res_vld), .o_res(o_res)
    );

    qbfe_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_item(i_item), .o_res_vld(o_res_vld), .o_res(o_res),
        .o_errors(errors), .o_pending(pending)
    );

    // Counts cycles in which no item moves in either direction.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_res_vld) begin
            quiet <= 0;
        end else begin
            quiet <= quiet + 1;
            if (quiet >= STALL_LIMIT) begin
                $display("quartic_boundary_fit_extrema regression: fail");
                $finish;
            end
        end
    end

    task automatic push_item(t_in it);
        logic held;
        i_item <= it;
        start  <= 1'b1;
        do begin
            @(negedge i_clk);
            held = busy;
            @(posedge i_clk);
        end while (held);
        if ($urandom_range(99) < idle_pct) begin
            // An idle gap with start low, so start is never lowered and raised at one edge.
            start <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < idle_pct)
                @(posedge i_clk);
        end
    endtask

    function automatic t_q near_q(int mag);
        return t_q'($signed($urandom_range(2 * mag)) - mag);
    endfunction

    function automatic t_in make_item();
        t_in it;
        int  kind;
        kind = $urandom_range(99);
        if (kind < 20) begin
            it = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                  31'($urandom())};
            if ($urandom_range(3) == 0) it.duration = 31'($urandom_range(255));
        end else begin
            // Plausible motion: moderate values over a duration of up to 10.0 in Q16.16.
            it.start_pos = near_q(1000 << 16);
            it.start_vel = near_q(50 << 16);
            it.start_acc = near_q(20 << 16);
            it.end_vel   = near_q(50 << 16);
            it.end_acc   = near_q(20 << 16);
            if (kind < 25) it.end_acc = it.start_acc;
            it.duration  = 31'($urandom_range(10 << 16, 1 << 12));
            if (kind < 30) it.duration = 31'($urandom_range(3));
        end
        return it;
    endfunction

    t_in d;

    initial begin
        quiet = 0;
        idle_pct = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        d = '0;
        push_item(d);
        d = '{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
              32'sh7fffffff, 31'h7fffffff};
        push_item(d);
        d = '{32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000,
              32'sh80000000, 31'h7fffffff};
        push_item(d);
        d = '{32'sh80000000, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff,
              32'sh80000000, 31'd1};
        push_item(d);
        // Zero duration with odd and negative accelerations.
        d = '{32'sd5, 32'sd7, -32'sd3, 32'sd1, 32'sd2, 31'd0};
        push_item(d);
        d = '{32'sh80000000, 32'sh7fffffff, 32'sh80000001, 32'sd0, 32'sd0, 31'd0};
        push_item(d);
        // Constant acceleration: no quartic term and so no vertex.
        d = '{32'sd0, 32'sd0, 32'sd131072, 32'sd131072, 32'sd131072, 31'd65536};
        push_item(d);
        // Vertex inside the interval, in two items.
        d = '{32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd65536, 31'd131072};
        push_item(d);
        d = '{32'sd0, 32'sd0, 32'sd65536, 32'sd655360, -32'sd65536, 31'd196608};
        push_item(d);
        d = '{32'sd100, -32'sd65536, 32'sd65536, 32'sd65536, 32'sd0, 31'd1};
        push_item(d);
        d = '{32'sd0, 32'sd65536, -32'sd65536, -32'sd65536, 32'sd0, 31'h7fffffff};
        push_item(d);
        d = '{32'sd1, -32'sd1, 32'sd1, -32'sd1, 32'sd1, 31'd1};
        push_item(d);

        for (int ph = 0; ph < 4; ph++) begin
            idle_pct = (ph == 1) ? 85 : (ph == 3) ? 22 : 0;
            for (int n = 0; n < 250; n++)
                push_item(make_item());
        end
        start <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (errors == 0) begin
            $display("quartic_boundary_fit_extrema regression: pass");
        end else begin
            $display("quartic_boundary_fit_extrema regression: fail");
        end
        $finish;
    end

endmodule
